FILE: rtl/core/pdtth_pkg.sv
// ----------------------------------------------------------------------------
// PD turn-to-heading package
// Shared constants, configuration register indexes, handshake structs between
// the top level and the sequencer, and the sequencer's microcode ROM.
// ----------------------------------------------------------------------------
package pdtth_pkg;

    localparam int TARGET_BITS = 18;
    localparam int GAIN_BITS   = 16;
    localparam int RUN_BITS    = 4;
    localparam int TICK_BITS   = 16;
    localparam int VOLT_BITS   = 5;
    localparam int VOLT_MAX    = 12;
    localparam int CFG_IDX_BITS = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_KP            = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KD_RATE       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FF_MAG        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACCURACY      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_BAND   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_NEEDED = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEOUT_TICKS = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VOLT_SCALE    = 3'd7;

    // Register values after reset.
    localparam logic [GAIN_BITS-1:0] KP_RESET            = 16'd448;
    localparam logic [GAIN_BITS-1:0] KD_RATE_RESET       = 16'd5120;
    localparam logic [GAIN_BITS-1:0] FF_MAG_RESET        = 16'd4301;
    localparam logic [GAIN_BITS-1:0] ACCURACY_RESET      = 16'd77;
    localparam logic [GAIN_BITS-1:0] SETTLE_BAND_RESET   = 16'd102;
    localparam logic [RUN_BITS-1:0]  SETTLE_NEEDED_RESET = 4'd8;
    localparam logic [TICK_BITS-1:0] TIMEOUT_TICKS_RESET = 16'd250;
    localparam logic [GAIN_BITS-1:0] VOLT_SCALE_RESET    = 16'd7864;

    // Control and status between the top level and the sequencer.
    typedef struct packed {
        logic go;
        logic ack;
    } t_seq_ctl;

    typedef struct packed {
        logic done;
    } t_seq_sts;

    // Microcode.
    typedef enum logic [3:0] {
        U_NOP,
        U_ERR,
        U_LD_KP,
        U_MAC,
        U_LD_KD,
        U_FF,
        U_LD_VS,
        U_VOLT,
        U_HOLD
    } t_uop;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_GO,
        C_CNT_NZ,
        C_NO_ACK
    } t_cond;

    typedef logic [3:0] t_pc;

    typedef struct packed {
        t_uop  uop;
        t_cond cond;
        t_pc   target;
    } t_uword;

    localparam t_pc PC_IDLE   = 4'd0;
    localparam t_pc PC_ERR    = 4'd1;
    localparam t_pc PC_LD_KP  = 4'd2;
    localparam t_pc PC_MAC_KP = 4'd3;
    localparam t_pc PC_LD_KD  = 4'd4;
    localparam t_pc PC_MAC_KD = 4'd5;
    localparam t_pc PC_FF     = 4'd6;
    localparam t_pc PC_LD_VS  = 4'd7;
    localparam t_pc PC_MAC_VS = 4'd8;
    localparam t_pc PC_VOLT   = 4'd9;
    localparam t_pc PC_HOLD   = 4'd10;
    localparam t_pc PC_RET    = 4'd11;

    // A taken condition jumps to the target; otherwise the program falls through.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_IDLE:   w = '{uop: U_NOP,   cond: C_NO_GO,  target: PC_IDLE};
            PC_ERR:    w = '{uop: U_ERR,   cond: C_NEXT,   target: PC_IDLE};
            PC_LD_KP:  w = '{uop: U_LD_KP, cond: C_NEXT,   target: PC_IDLE};
            PC_MAC_KP: w = '{uop: U_MAC,   cond: C_CNT_NZ, target: PC_MAC_KP};
            PC_LD_KD:  w = '{uop: U_LD_KD, cond: C_NEXT,   target: PC_IDLE};
            PC_MAC_KD: w = '{uop: U_MAC,   cond: C_CNT_NZ, target: PC_MAC_KD};
            PC_FF:     w = '{uop: U_FF,    cond: C_NEXT,   target: PC_IDLE};
            PC_LD_VS:  w = '{uop: U_LD_VS, cond: C_NEXT,   target: PC_IDLE};
            PC_MAC_VS: w = '{uop: U_MAC,   cond: C_CNT_NZ, target: PC_MAC_VS};
            PC_VOLT:   w = '{uop: U_VOLT,  cond: C_NEXT,   target: PC_IDLE};
            PC_HOLD:   w = '{uop: U_HOLD,  cond: C_NO_ACK, target: PC_HOLD};
            PC_RET:    w = '{uop: U_NOP,   cond: C_ALWAYS, target: PC_IDLE};
            default:   w = '{uop: U_NOP,   cond: C_ALWAYS, target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/pdtth_in_if.sv
// ----------------------------------------------------------------------------
// PD turn-to-heading command channel
// Valid/ready channel carrying start items and heading samples.
// ----------------------------------------------------------------------------
interface pdtth_in_if #(
    parameter int ANGLE_BITS = 24
) ();
    import pdtth_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [TARGET_BITS-1:0] target;
    logic signed [ANGLE_BITS-1:0]  heading;

    modport source (output valid, kind, target, heading, input ready);
    modport sink   (input valid, kind, target, heading, output ready);
endinterface

FILE: rtl/core/pdtth_out_if.sv
// ----------------------------------------------------------------------------
// PD turn-to-heading result channel
// Valid/ready channel carrying one drive command per command transaction.
// ----------------------------------------------------------------------------
interface pdtth_out_if ();
    import pdtth_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [VOLT_BITS-1:0] left_volts;
    logic signed [VOLT_BITS-1:0] right_volts;
    logic                        brake;
    logic [1:0]                  status;

    modport source (output valid, left_volts, right_volts, brake, status, input ready);
    modport sink   (input valid, left_volts, right_volts, brake, status, output ready);
endinterface

FILE: rtl/core/pdtth_seq.sv
// ----------------------------------------------------------------------------
// PD turn-to-heading microcoded sequencer
// Computes the error and the saturated left drive volts for one heading sample
// with a shared shift-add accumulator driven by a microcode ROM.
// ----------------------------------------------------------------------------
module pdtth_seq #(
    parameter int  ANGLE_BITS = 24,
    localparam int EW = ((ANGLE_BITS > pdtth_pkg::TARGET_BITS) ?
                         ANGLE_BITS : pdtth_pkg::TARGET_BITS) + 1
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  pdtth_pkg::t_seq_ctl                      i_ctl,
    input  logic signed [pdtth_pkg::TARGET_BITS-1:0] i_target,
    input  logic signed [ANGLE_BITS-1:0]             i_heading,
    input  logic signed [EW-1:0]                     i_prior,
    input  logic [pdtth_pkg::GAIN_BITS-1:0]          i_kp,
    input  logic [pdtth_pkg::GAIN_BITS-1:0]          i_kd,
    input  logic [pdtth_pkg::GAIN_BITS-1:0]          i_ff,
    input  logic [pdtth_pkg::GAIN_BITS-1:0]          i_vs,
    output pdtth_pkg::t_seq_sts                      o_sts,
    output logic signed [EW-1:0]                     o_err,
    output logic signed [pdtth_pkg::VOLT_BITS-1:0]   o_volts
);
    import pdtth_pkg::*;

    // Accumulator holds the Q16 speed and later the volts product.
    localparam int AW = EW + 20;
    localparam int QW = AW - 16;

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w;
    logic   take;

    logic signed [AW-1:0]        r_acc;
    logic signed [AW-1:0]        r_mc;
    logic [GAIN_BITS-1:0]        r_mq;
    logic [3:0]                  r_cnt;
    logic signed [EW-1:0]        r_err;
    logic                        r_neg;
    logic signed [VOLT_BITS-1:0] r_volts;

    logic signed [EW-1:0] err_c;
    logic signed [EW:0]   diff_c;
    logic signed [AW-1:0] ff_ext;
    logic [AW-1:0]        acc_abs;
    logic [QW-1:0]        q;
    logic [3:0]           vmag;

    assign w = ucode(r_pc);

    always_comb begin
        unique case (w.cond)
            C_NEXT:   take = 1'b0;
            C_ALWAYS: take = 1'b1;
            C_NO_GO:  take = !i_ctl.go;
            C_CNT_NZ: take = (r_cnt != 4'd0);
            C_NO_ACK: take = !i_ctl.ack;
            default:  take = 1'b1;
        endcase
        n_pc = take ? w.target : t_pc'(r_pc + 4'd1);
    end

    assign err_c   = EW'(i_target) - EW'(i_heading);
    assign diff_c  = (EW+1)'(r_err) - (EW+1)'(i_prior);
    assign ff_ext  = AW'({i_ff, 8'h00});
    assign acc_abs = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
    assign q       = r_acc[AW-1:16];
    assign vmag    = (q > QW'(VOLT_MAX)) ? 4'(VOLT_MAX) : q[3:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (w.uop)
            U_ERR: begin
                r_err <= err_c;
                r_acc <= '0;
            end
            U_LD_KP: begin
                r_mc  <= AW'(r_err);
                r_mq  <= i_kp;
                r_cnt <= 4'd15;
            end
            U_LD_KD: begin
                r_mc  <= AW'(diff_c);
                r_mq  <= i_kd;
                r_cnt <= 4'd15;
            end
            U_MAC: begin
                if (r_mq[0]) begin
                    r_acc <= r_acc + r_mc;
                end
                r_mc  <= r_mc <<< 1;
                r_mq  <= r_mq >> 1;
                r_cnt <= r_cnt - 4'd1;
            end
            U_FF: begin
                // The constant push follows the sign of the error, and none at zero.
                if (r_err > 0) begin
                    r_acc <= r_acc + ff_ext;
                end else if (r_err < 0) begin
                    r_acc <= r_acc - ff_ext;
                end
            end
            U_LD_VS: begin
                r_neg <= r_acc[AW-1];
                r_mc  <= AW'(acc_abs >> 16);
                r_mq  <= i_vs;
                r_acc <= '0;
                r_cnt <= 4'd15;
            end
            U_VOLT: begin
                r_volts <= r_neg ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
            end
            U_NOP, U_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    assign o_sts.done = (w.uop == U_HOLD);
    assign o_err      = r_err;
    assign o_volts    = r_volts;

endmodule

FILE: rtl/core/pd_turn_to_heading_top.sv
// ----------------------------------------------------------------------------
// PD turn-to-heading controller, top level
// Turns a robot in place toward a target angle and reports drive commands.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on i_cmd as valid/ready transactions. A start command
// (kind 0) loads the target and begins a turn; a heading sample (kind 1)
// produces a drive command while turning. Every command transaction yields
// exactly one result transaction on o_res: left and right volts, a brake flag
// and a status code. The user writes configuration registers through i_cfg_we,
// i_cfg_idx and i_cfg_data only while idle; the block does not enforce this.
// Sequencing. One command is in work at a time: the next command is accepted
// only after the result of the current one is written to the output register.
// Start commands and samples outside a turn are written there as soon as the
// output register is free. A sample during a turn first goes through the
// sequencer, which runs three 16-step shift-add multiplies (proportional,
// derivative, volt scaling) on one shared accumulator, plus setup steps, and
// holds its result until the output register is free to take it.
// Reset. Synchronous, active low: registers take their default values, the
// phase returns to idle and no result is pending.
// Stalls. The output register holds a finished result until o_res.ready. The
// next command is accepted meanwhile; its result waits until the slot frees.
// ----------------------------------------------------------------------------
module pd_turn_to_heading_top #(
    parameter int ANGLE_BITS = 24
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    pdtth_in_if.sink                                i_cmd,
    pdtth_out_if.source                             o_res,
    input  logic                                    i_cfg_we,
    input  logic [pdtth_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [pdtth_pkg::GAIN_BITS-1:0]         i_cfg_data
);
    import pdtth_pkg::*;

    localparam int EW = ((ANGLE_BITS > TARGET_BITS) ? ANGLE_BITS : TARGET_BITS) + 1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_TURN    = 2'd1,
        PH_DONE    = 2'd2,
        PH_TIMEOUT = 2'd3
    } t_phase;

    // Configuration registers.
    logic [GAIN_BITS-1:0] r_kp;
    logic [GAIN_BITS-1:0] r_kd;
    logic [GAIN_BITS-1:0] r_ff;
    logic [GAIN_BITS-1:0] r_accuracy;
    logic [GAIN_BITS-1:0] r_band;
    logic [RUN_BITS-1:0]  r_needed;
    logic [TICK_BITS-1:0] r_timeout;
    logic [GAIN_BITS-1:0] r_vs;

    // Turn state.
    t_phase                        r_phase;
    logic signed [TARGET_BITS-1:0] r_target;
    logic signed [EW-1:0]          r_prior;
    logic [RUN_BITS-1:0]           r_run;
    logic [TICK_BITS-1:0]          r_tick;

    // Command in work.
    logic                          r_busy;
    logic                          r_comp;
    logic                          r_kind;
    logic                          r_go;
    logic signed [TARGET_BITS-1:0] r_tin;
    logic signed [ANGLE_BITS-1:0]  r_head;

    // Output register.
    logic                        r_ovalid;
    logic signed [VOLT_BITS-1:0] r_left;
    logic signed [VOLT_BITS-1:0] r_right;
    logic                        r_brake;
    logic [1:0]                  r_status;

    t_seq_ctl                    seq_ctl;
    t_seq_sts                    seq_sts;
    logic signed [EW-1:0]        seq_err;
    logic signed [VOLT_BITS-1:0] seq_volts;

    logic                        in_fire;
    logic                        slot_free;
    logic                        write_now;
    logic [EW-1:0]               aerr;
    logic [RUN_BITS-1:0]         n_run;
    logic [TICK_BITS-1:0]        n_tick;
    logic                        hit_timeout;
    logic                        hit_settled;
    logic signed [VOLT_BITS-1:0] n_left;
    logic                        n_brake;
    t_phase                      n_phase;

    assign i_cmd.ready = !r_busy;
    assign in_fire     = i_cmd.valid && !r_busy;
    assign slot_free   = !r_ovalid || o_res.ready;
    assign write_now   = r_busy && slot_free && (!r_comp || seq_sts.done);

    assign seq_ctl.go  = r_go;
    assign seq_ctl.ack = write_now && r_comp;

    pdtth_seq #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (seq_ctl),
        .i_target  (r_target),
        .i_heading (r_head),
        .i_prior   (r_prior),
        .i_kp      (r_kp),
        .i_kd      (r_kd),
        .i_ff      (r_ff),
        .i_vs      (r_vs),
        .o_sts     (seq_sts),
        .o_err     (seq_err),
        .o_volts   (seq_volts)
    );

    // Settle run, tick count and the end-of-turn decision for a computed sample.
    // A timeout wins over settling and still reports the computed volts.
    always_comb begin
        aerr = seq_err[EW-1] ? EW'(-seq_err) : EW'(seq_err);
        if (aerr <= EW'(r_band)) begin
            n_run = (r_run == '1) ? r_run : RUN_BITS'(r_run + 1'b1);
        end else begin
            n_run = '0;
        end
        n_tick      = (r_tick == '1) ? r_tick : TICK_BITS'(r_tick + 1'b1);
        hit_timeout = (n_tick >= r_timeout);
        hit_settled = (aerr < EW'(r_accuracy)) && (n_run >= r_needed);
        priority if (hit_timeout) begin
            n_left  = seq_volts;
            n_brake = 1'b0;
            n_phase = PH_TIMEOUT;
        end else if (hit_settled) begin
            n_left  = '0;
            n_brake = 1'b1;
            n_phase = PH_DONE;
        end else begin
            n_left  = seq_volts;
            n_brake = 1'b0;
            n_phase = PH_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= KP_RESET;
            r_kd      <= KD_RATE_RESET;
            r_ff      <= FF_MAG_RESET;
            r_accuracy <= ACCURACY_RESET;
            r_band    <= SETTLE_BAND_RESET;
            r_needed  <= SETTLE_NEEDED_RESET;
            r_timeout <= TIMEOUT_TICKS_RESET;
            r_vs      <= VOLT_SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP:            r_kp       <= i_cfg_data;
                CFG_KD_RATE:       r_kd       <= i_cfg_data;
                CFG_FF_MAG:        r_ff       <= i_cfg_data;
                CFG_ACCURACY:      r_accuracy <= i_cfg_data;
                CFG_SETTLE_BAND:   r_band     <= i_cfg_data;
                CFG_SETTLE_NEEDED: r_needed   <= i_cfg_data[RUN_BITS-1:0];
                CFG_TIMEOUT_TICKS: r_timeout  <= i_cfg_data[TICK_BITS-1:0];
                CFG_VOLT_SCALE:    r_vs       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Command capture; the go pulse toward the sequencer is set in the control block below.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind <= i_cmd.kind;
            r_tin  <= i_cmd.target;
            r_head <= i_cmd.heading;
        end
    end

    // Control state, turn state and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_comp   <= 1'b0;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
            r_phase  <= PH_IDLE;
            r_target <= '0;
            r_prior  <= '0;
            r_run    <= '0;
            r_tick   <= '0;
        end else begin
            r_go <= in_fire && i_cmd.kind && (r_phase == PH_TURN);
            if (in_fire) begin
                r_busy <= 1'b1;
                r_comp <= i_cmd.kind && (r_phase == PH_TURN);
            end else if (write_now) begin
                r_busy <= 1'b0;
            end

            if (write_now) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end

            if (write_now) begin
                if (!r_kind) begin
                    // Start a turn.
                    r_target <= r_tin;
                    r_prior  <= '0;
                    r_run    <= '0;
                    r_tick   <= '0;
                    r_phase  <= PH_TURN;
                    r_left   <= '0;
                    r_right  <= '0;
                    r_brake  <= 1'b0;
                    r_status <= PH_TURN;
                end else if (!r_comp) begin
                    // Sample outside a turn reports the phase and leaves state alone.
                    r_left   <= '0;
                    r_right  <= '0;
                    r_brake  <= 1'b0;
                    r_status <= r_phase;
                end else begin
                    r_prior  <= seq_err;
                    r_run    <= n_run;
                    r_tick   <= n_tick;
                    r_phase  <= n_phase;
                    r_left   <= n_left;
                    r_right  <= -n_left;
                    r_brake  <= n_brake;
                    r_status <= n_phase;
                end
            end
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.left_volts  = r_left;
    assign o_res.right_volts = r_right;
    assign o_res.brake       = r_brake;
    assign o_res.status      = r_status;

endmodule
